[hdl/canny_non_max_suppression_assert.svh]
// Assertion macros shared by the non-maximum suppression RTL.
// All checks sample on aclk; the reset is aresetn, synchronous and active low.
`ifndef CANNY_NON_MAX_SUPPRESSION_ASSERT_SVH
`define CANNY_NON_MAX_SUPPRESSION_ASSERT_SVH

// Check that is switched off while reset is asserted
`define CNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that also holds across reset
`define CNMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[hdl/cnms_pkg.sv]
package cnms_pkg;

    // Line store depth and frame size limits
    localparam int MAX_LINE = 256;
    localparam int MAX_ROWS = 256;

    localparam int PIX_W   = 8;                   // magnitude and direction width
    localparam int DIM_W   = 9;                   // configuration register width
    localparam int COL_W   = $clog2(MAX_LINE);    // column counter / line store address
    localparam int ROW_W   = $clog2(MAX_ROWS);    // row counter
    localparam int COORD_W = 8;                   // pixel_row / pixel_col on the result
    localparam int CFG_IDX_W = 1;
    localparam int MIN_DIM = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Neighbor pair picked by the direction code
    typedef enum logic [1:0] {
        DIR_HORZ      = 2'd0,   // left / right
        DIR_DIAG_UP   = 2'd1,   // upper-right / lower-left
        DIR_VERT      = 2'd2,   // up / down
        DIR_DIAG_DOWN = 2'd3    // upper-left / lower-right
    } dir_class_t;

    // Position of a pixel in the frame, with its end-of-row/end-of-frame flags
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             col_end;
        logic             row_end;
    } pos_t;

    // Angle folded into half a turn: the top code bit is 180 degrees
    function automatic dir_class_t dir_class(input logic [PIX_W-1:0] d);
        logic [PIX_W-2:0] f;
        f = d[PIX_W-2:0];
        if (f <= 7'd15 || f >= 7'd112) begin
            return DIR_HORZ;
        end else if (f <= 7'd47) begin
            return DIR_DIAG_UP;
        end else if (f <= 7'd79) begin
            return DIR_VERT;
        end
        return DIR_DIAG_DOWN;
    endfunction

    // Out-of-range sizes act as the nearest legal value
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] hi);
        if (v < DIM_W'(MIN_DIM)) begin
            return DIM_W'(MIN_DIM);
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

endpackage

[hdl/canny_non_max_suppression.sv]
// Canny non-maximum suppression, 3x3 window.
// Input stream (s_axis): one pixel per beat in raster order, s_tdata holds the
// gradient magnitude and direction code. Results (m_axis): one beat per
// interior pixel with the kept magnitude (or 0), its row and column; m_tlast
// marks the last interior pixel of the frame. Border pixels give no beat.
// Frame size comes from the line_width and frame_height registers, written
// through the cfg_wr_* port; the user must write them only while no pixel is
// in flight, as the block itself does not enforce this. A pixel passes the
// input stage, then the result register. Throughput: one pixel per clock while
// m_tready is high; the limit is the single read and single write per cycle on each line store RAM.
// Reset empties the input stage and result register and returns the raster
// position to row 0, column 0 with both sizes at 256; line store contents are
// left as they are. When m_tready is low the result is held and one more pixel
// is taken into the input stage, after which s_tready drops until the result
// beat goes out.
`include "canny_non_max_suppression_assert.svh"

module canny_non_max_suppression
    import cnms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [DIM_W-1:0]     cfg_wr_data,
    // Pixel input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,    // [7:0] magnitude, [15:8] direction
    // Result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,    // [7:0] suppressed_value, [15:8] pixel_row,
                                             // [23:16] pixel_col
    output logic                 m_tlast     // frame_last
);

    logic             accept, advance, interior;
    pos_t             pos;

    // Input stage
    logic             a_valid_reg, a_valid_next;
    logic [PIX_W-1:0] a_mag_reg, a_dir_reg;
    pos_t             a_pos_reg;

    // Line store read data, aligned with the input stage
    logic [PIX_W-1:0] older_rd, newer_rd, dir_rd;
    logic [PIX_W-1:0] kept_value;

    // Result register
    logic               m_valid_reg, m_valid_next;
    logic [PIX_W-1:0]   m_value_reg;
    logic [COORD_W-1:0] m_row_reg, m_col_reg;
    logic               m_last_reg;

    assign advance  = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign interior = (a_pos_reg.row >= ROW_W'(2)) && (a_pos_reg.col >= COL_W'(2));

    cnms_position u_position (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .step         (accept),
        .pos          (pos)
    );

    // Line stores: read at the incoming column, written back as the pixel moves on
    cnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_older_mag_line (
        .aclk  (aclk),
        .we    (advance),
        .waddr (a_pos_reg.col),
        .wdata (newer_rd),
        .re    (accept),
        .raddr (pos.col),
        .rdata (older_rd)
    );

    cnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_newer_mag_line (
        .aclk  (aclk),
        .we    (advance),
        .waddr (a_pos_reg.col),
        .wdata (a_mag_reg),
        .re    (accept),
        .raddr (pos.col),
        .rdata (newer_rd)
    );

    cnms_ram #(.WIDTH(PIX_W), .DEPTH(MAX_LINE)) u_centre_dir_line (
        .aclk  (aclk),
        .we    (advance),
        .waddr (a_pos_reg.col),
        .wdata (a_dir_reg),
        .re    (accept),
        .raddr (pos.col),
        .rdata (dir_rd)
    );

    cnms_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .col_top    (older_rd),
        .col_mid    (newer_rd),
        .col_bot    (a_mag_reg),
        .dir_new    (dir_rd),
        .kept_value (kept_value)
    );

    // Input stage control
    always_comb begin
        a_valid_next = a_valid_reg;
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (advance) begin
            a_valid_next = 1'b0;
        end
    end

    // Result register control
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = interior;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_mag_reg <= s_tdata[7:0];
            a_dir_reg <= s_tdata[15:8];
            a_pos_reg <= pos;
        end
        if (advance) begin
            m_value_reg <= kept_value;
            m_row_reg   <= COORD_W'(a_pos_reg.row - ROW_W'(1));
            m_col_reg   <= COORD_W'(a_pos_reg.col - COL_W'(1));
            m_last_reg  <= a_pos_reg.row_end && a_pos_reg.col_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_value_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    `CNMS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_tvalid && !a_valid_reg), "pipeline not empty after reset")
    `CNMS_ASSERT(a_ram_no_collide, (accept && advance) |-> (pos.col != a_pos_reg.col), "line store read and write collide")
    `CNMS_ASSERT(a_result_from_stage, $rose(m_tvalid) |-> $past(advance && interior), "result appeared without a pixel")
    `CNMS_ASSERT(a_result_interior, m_tvalid |-> (m_tdata[15:8] != 8'd0 && m_tdata[23:16] != 8'd0), "border pixel produced a result")

endmodule

[hdl/cnms_ram.sv]
module cnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/cnms_position.sv]
module cnms_position
    import cnms_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [DIM_W-1:0]     cfg_wr_data,
    input  logic                 step,
    output pos_t                 pos
);

    logic [DIM_W-1:0] line_width_reg, line_width_next;
    logic [DIM_W-1:0] frame_height_reg, frame_height_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_end, row_end;

    // End flags for the pixel now at the input
    assign col_end = (DIM_W'(col_reg) + DIM_W'(1)) >= line_width_reg;
    assign row_end = (DIM_W'(row_reg) + DIM_W'(1)) >= frame_height_reg;

    always_comb begin
        pos.col     = col_reg;
        pos.row     = row_reg;
        pos.col_end = col_end;
        pos.row_end = row_end;
    end

    // Size registers, clamped on write
    always_comb begin
        line_width_next   = line_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_LINE_WIDTH:   line_width_next   = clamp_dim(cfg_wr_data, DIM_W'(MAX_LINE));
                REG_FRAME_HEIGHT: frame_height_next = clamp_dim(cfg_wr_data, DIM_W'(MAX_ROWS));
                default: ;
            endcase
        end
    end

    // Raster counters step once per accepted beat
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (step) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= DIM_W'(MAX_LINE);
            frame_height_reg <= DIM_W'(MAX_ROWS);
            col_reg          <= '0;
            row_reg          <= '0;
        end else begin
            line_width_reg   <= line_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
        end
    end

endmodule

[hdl/cnms_window.sv]
module cnms_window
    import cnms_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [PIX_W-1:0] col_top,     // older line store
    input  logic [PIX_W-1:0] col_mid,     // newer line store
    input  logic [PIX_W-1:0] col_bot,     // incoming pixel
    input  logic [PIX_W-1:0] dir_new,     // direction of the middle row, new column
    output logic [PIX_W-1:0] kept_value
);

    // Two stored columns; the third is the one arriving now
    logic [PIX_W-1:0] mid_col_reg   [3];
    logic [PIX_W-1:0] right_col_reg [3];
    logic [PIX_W-1:0] dir_right_reg;

    logic [PIX_W-1:0] centre, n1, n2;
    dir_class_t       cls;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                mid_col_reg[k]   <= '0;
                right_col_reg[k] <= '0;
            end
            dir_right_reg <= '0;
        end else if (advance) begin
            for (int k = 0; k < 3; k++) begin
                mid_col_reg[k] <= right_col_reg[k];
            end
            right_col_reg[0] <= col_top;
            right_col_reg[1] <= col_mid;
            right_col_reg[2] <= col_bot;
            dir_right_reg    <= dir_new;
        end
    end

    // After the shift the centre is the old right column, middle row
    assign centre = right_col_reg[1];
    assign cls    = dir_class(dir_right_reg);

    // Neighbor pair select
    always_comb begin
        case (cls)
            DIR_HORZ: begin
                n1 = mid_col_reg[1];
                n2 = col_mid;
            end
            DIR_DIAG_UP: begin
                n1 = col_top;
                n2 = mid_col_reg[2];
            end
            DIR_VERT: begin
                n1 = right_col_reg[0];
                n2 = right_col_reg[2];
            end
            DIR_DIAG_DOWN: begin
                n1 = mid_col_reg[0];
                n2 = col_bot;
            end
            default: begin
                n1 = '0;
                n2 = '0;
            end
        endcase
    end

    assign kept_value = (centre >= n1 && centre >= n2) ? centre : '0;

endmodule
